/* src/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, codes and types for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 16;
    localparam int CAP_W   = 5;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [COUNT_W-1:0]      count_t;

    localparam count_t COUNT_MAX = 16'hFFFF;
    localparam count_t COUNT_ONE = 16'd1;
    localparam val_t   MISS_VALUE = -32'sd1;

endpackage

/* src/lfu_victim_sel.sv */
// ----------------------------------------------------------------------------
// lfu_victim_sel
// Selection tree: lowest use count among valid entries, oldest on a tie.
// ----------------------------------------------------------------------------
module lfu_victim_sel #(
    parameter int ENTRIES = 16
) (
    input  logic [ENTRIES-1:0]                      valid,
    input  lfu_pkg::count_t                         count [ENTRIES],
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rank [ENTRIES],
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] victim_idx
);

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEAVES  = 1 << IDX_W;
    localparam int NODES   = 2 * LEAVES - 1;
    localparam int SCORE_W = lfu_pkg::COUNT_W + IDX_W;

    logic               node_ok    [NODES];
    logic [SCORE_W-1:0] node_score [NODES];
    logic [IDX_W-1:0]   node_idx   [NODES];

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++) begin : g_leaf
            if (g < ENTRIES) begin : g_real
                assign node_ok[LEAVES-1+g]    = valid[g];
                assign node_score[LEAVES-1+g] = {count[g], ~rank[g]};
            end else begin : g_pad
                assign node_ok[LEAVES-1+g]    = 1'b0;
                assign node_score[LEAVES-1+g] = '0;
            end
            assign node_idx[LEAVES-1+g] = IDX_W'(g);
        end

        for (g = 0; g < LEAVES - 1; g++) begin : g_node
            logic take_b;
            assign take_b = node_ok[2*g+2] &&
                            (!node_ok[2*g+1] || (node_score[2*g+2] < node_score[2*g+1]));
            assign node_ok[g]    = node_ok[2*g+1] || node_ok[2*g+2];
            assign node_score[g] = take_b ? node_score[2*g+2] : node_score[2*g+1];
            assign node_idx[g]   = take_b ? node_idx[2*g+2] : node_idx[2*g+1];
        end
    endgenerate

    assign victim_idx = node_idx[0];

endmodule

/* src/lfu_cache_table_unit.sv */
// ----------------------------------------------------------------------------
// lfu_cache_table_unit
// Key-value cache with least-frequently-used replacement, LRU tie-break.
// ----------------------------------------------------------------------------
// The block takes one get or put beat per clock while the output is not
// stalled, and returns one result beat for each through the input register
// and then the result register. The rate is set by a single pass through the
// parallel key compare and the count/age selection tree between the input
// register and the result register. The table lives in flip-flops with a
// valid bit per entry; it is usable right after reset with no clearing pass.
// Capacity may be written at any time the block is idle.
module lfu_cache_table_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic signed [lfu_pkg::KEY_W-1:0]    lookup_key,
    input  logic signed [lfu_pkg::VAL_W-1:0]    write_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic signed [lfu_pkg::VAL_W-1:0]    read_value,
    output logic                                evicted,
    output logic signed [lfu_pkg::KEY_W-1:0]    evicted_key,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]           capacity_in_use
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;

    logic [lfu_pkg::CAP_W-1:0] cap_reg;
    logic [OCC_W-1:0]          occ_reg, occ_next;

    logic          s1_valid_reg, s1_valid_next;
    logic          s1_op_reg;
    lfu_pkg::key_t s1_key_reg;
    lfu_pkg::val_t s1_val_reg;

    logic          out_valid_reg, out_valid_next;
    logic          found_reg;
    lfu_pkg::val_t read_value_reg;
    logic          evicted_reg;
    lfu_pkg::key_t evicted_key_reg;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    lfu_pkg::key_t      key_reg   [ENTRIES];
    lfu_pkg::key_t      key_next  [ENTRIES];
    lfu_pkg::val_t      value_reg [ENTRIES];
    lfu_pkg::val_t      value_next[ENTRIES];
    lfu_pkg::count_t    count_reg [ENTRIES];
    lfu_pkg::count_t    count_next[ENTRIES];
    logic [IDX_W-1:0]   rank_reg  [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];

    logic               in_take, advance;
    logic [ENTRIES-1:0] hit_vec, free_vec, free_onehot, victim_onehot;
    logic [ENTRIES-1:0] pivot_onehot, ins_onehot;
    logic               hit_any, is_put, put_ok, has_room;
    logic               do_touch, do_insert, do_evict, age_all;
    lfu_pkg::val_t      hit_value;
    logic [IDX_W-1:0]   hit_rank, pivot_rank, victim_idx;
    logic [CMP_W-1:0]   cap_ext, cap_eff, occ_ext;

    // handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    lfu_victim_sel #(
        .ENTRIES (ENTRIES)
    ) u_victim_sel (
        .valid      (valid_reg),
        .count      (count_reg),
        .rank       (rank_reg),
        .victim_idx (victim_idx)
    );

    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]       = valid_reg[i] && (key_reg[i] == s1_key_reg);
            victim_onehot[i] = (victim_idx == IDX_W'(i));
            if (hit_vec[i])
            begin
                hit_value = hit_value | value_reg[i];
                hit_rank  = hit_rank | rank_reg[i];
            end
        end
    end

    assign hit_any     = |hit_vec;
    assign free_vec    = ~valid_reg;
    assign free_onehot = free_vec & (~free_vec + ENTRIES'(1));

    assign cap_ext  = CMP_W'(cap_reg);
    assign cap_eff  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    assign occ_ext  = CMP_W'(occ_reg);
    assign has_room = occ_ext < cap_eff;

    assign is_put    = (s1_op_reg == lfu_pkg::OP_PUT);
    assign put_ok    = is_put && (cap_eff != '0);
    assign do_touch  = hit_any && (!is_put || put_ok);
    assign do_insert = put_ok && !hit_any;
    assign do_evict  = do_insert && !has_room;
    assign age_all   = do_insert && has_room;

    assign pivot_onehot = do_touch ? hit_vec : (do_evict ? victim_onehot : '0);
    assign pivot_rank   = do_touch ? hit_rank : rank_reg[victim_idx];
    assign ins_onehot   = do_insert ? (has_room ? free_onehot : victim_onehot) : '0;

    // table update
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];
            if (advance)
            begin
                if (valid_reg[i] && !pivot_onehot[i] &&
                    (age_all || ((do_touch || do_evict) && (rank_reg[i] < pivot_rank))))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
                if (do_touch && hit_vec[i])
                begin
                    rank_next[i] = '0;
                    if (count_reg[i] != lfu_pkg::COUNT_MAX)
                    begin
                        count_next[i] = count_reg[i] + lfu_pkg::COUNT_ONE;
                    end
                    if (is_put)
                    begin
                        value_next[i] = s1_val_reg;
                    end
                end
                if (ins_onehot[i])
                begin
                    valid_next[i] = 1'b1;
                    key_next[i]   = s1_key_reg;
                    value_next[i] = s1_val_reg;
                    count_next[i] = lfu_pkg::COUNT_ONE;
                    rank_next[i]  = '0;
                end
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (advance && age_all)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_comb
    begin
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lfu_pkg::CAP_RESET;
            occ_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= capacity_in_use;
            end
            occ_reg       <= occ_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg  <= operation;
            s1_key_reg <= lookup_key;
            s1_val_reg <= write_value;
        end
        if (advance)
        begin
            found_reg       <= hit_any;
            read_value_reg  <= is_put ? '0 : (hit_any ? hit_value : lfu_pkg::MISS_VALUE);
            evicted_reg     <= do_evict;
            evicted_key_reg <= do_evict ? key_reg[victim_idx] : '0;
        end
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
        rank_reg  <= rank_next;
    end

endmodule

/* src/lfu_checker.sv */
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks for the LFU cache table, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             found,
    input logic signed [lfu_pkg::VAL_W-1:0] read_value,
    input logic                             evicted,
    input logic signed [lfu_pkg::KEY_W-1:0] evicted_key
);

    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(read_value)
                                   && $stable(evicted) && $stable(evicted_key))
        else $error("stalled result beat changed");

    a_evict_only_on_put_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !found && (read_value == '0))
        else $error("eviction reported on a hit or a get");

    a_no_evict_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> (evicted_key == '0))
        else $error("evicted key set without eviction");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (read_value == '0) || (read_value == lfu_pkg::MISS_VALUE))
        else $error("miss returned a stored value");

endmodule

bind lfu_cache_table_unit lfu_checker u_lfu_checker (.*);

/* test/lfu_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_result_checker
// Watches the request, result and capacity channels of the LFU cache table,
// keeps its own copy of the table, predicts one result per accepted request
// and compares each result beat field by field in order of arrival.
// ----------------------------------------------------------------------------
module lfu_result_checker #(
    parameter int ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      operation,
    input  lfu_pkg::key_t             lookup_key,
    input  lfu_pkg::val_t             write_value,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      found,
    input  lfu_pkg::val_t             read_value,
    input  logic                      evicted,
    input  lfu_pkg::key_t             evicted_key,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0] capacity_in_use,
    output int                        mismatches,
    output int                        lookups_in_flight
);

    localparam int AGE_W = $clog2(ENTRIES);

    typedef struct {
        logic          found;
        lfu_pkg::val_t read_value;
        logic          evicted;
        lfu_pkg::key_t evicted_key;
    } cache_reply_t;

    logic                      line_valid [ENTRIES];
    lfu_pkg::key_t             line_key   [ENTRIES];
    lfu_pkg::val_t             line_value [ENTRIES];
    lfu_pkg::count_t           line_uses  [ENTRIES];
    logic [AGE_W-1:0]          line_age   [ENTRIES];
    logic [lfu_pkg::CAP_W-1:0] lines_held;
    logic [lfu_pkg::CAP_W-1:0] capacity;
    cache_reply_t              pending_replies [$];

    function automatic void promote(int s);
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_age[i] < line_age[s])
                line_age[i]++;
        line_age[s] = '0;
        if (line_uses[s] != lfu_pkg::COUNT_MAX)
            line_uses[s]++;
    endfunction

    function automatic cache_reply_t access_cache(logic op, lfu_pkg::key_t k,
                                                  lfu_pkg::val_t v);
        cache_reply_t              r;
        int                        hit;
        int                        slot;
        int                        victim;
        logic [lfu_pkg::CAP_W-1:0] limit;
        hit    = -1;
        slot   = -1;
        victim = -1;
        limit  = (capacity > ENTRIES) ? lfu_pkg::CAP_W'(ENTRIES) : capacity;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && line_valid[i] && line_key[i] == k)
                hit = i;
        r.found       = (hit >= 0);
        r.read_value  = '0;
        r.evicted     = 1'b0;
        r.evicted_key = '0;
        if (op == lfu_pkg::OP_GET)
        begin
            if (hit >= 0)
            begin
                r.read_value = line_value[hit];
                promote(hit);
            end
            else
                r.read_value = lfu_pkg::MISS_VALUE;
            return r;
        end
        if (limit == 0)
            return r;
        if (hit >= 0)
        begin
            line_value[hit] = v;
            promote(hit);
            return r;
        end
        if (lines_held < limit)
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !line_valid[i])
                    slot = i;
        if (slot < 0)
        begin
            // lowest count first, oldest among equals
            for (int i = 0; i < ENTRIES; i++)
                if (line_valid[i] && (victim < 0 || line_uses[i] < line_uses[victim] ||
                    (line_uses[i] == line_uses[victim] && line_age[i] > line_age[victim])))
                    victim = i;
            for (int i = 0; i < ENTRIES; i++)
                if (line_valid[i] && line_age[i] > line_age[victim])
                    line_age[i]--;
            line_valid[victim] = 1'b0;
            lines_held--;
            r.evicted     = 1'b1;
            r.evicted_key = line_key[victim];
            slot          = victim;
        end
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i])
                line_age[i]++;
        line_valid[slot] = 1'b1;
        line_key[slot]   = k;
        line_value[slot] = v;
        line_uses[slot]  = lfu_pkg::COUNT_ONE;
        line_age[slot]   = '0;
        lines_held++;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cache_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                line_valid[i] = 1'b0;
                line_key[i]   = '0;
                line_value[i] = '0;
                line_uses[i]  = '0;
                line_age[i]   = '0;
            end
            lines_held = '0;
            capacity   = lfu_pkg::CAP_RESET;
            mismatches = 0;
            pending_replies.delete();
            lookups_in_flight <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity = capacity_in_use;
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("result beat with no request pending");
                    mismatches++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    compare_field("found", 32'(want.found), 32'(found));
                    compare_field("read_value", want.read_value, read_value);
                    compare_field("evicted", 32'(want.evicted), 32'(evicted));
                    compare_field("evicted_key", want.evicted_key, evicted_key);
                end
            end
            if (in_valid && !in_stall)
                pending_replies.push_back(access_cache(operation, lookup_key, write_value));
            lookups_in_flight <= pending_replies.size();
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives gets and puts into the LFU cache table across a series of capacity
// settings, with random gaps on both channels, a long result hold-off and a
// warm-up that forces evictions, and reports the verdict from the result
// checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int            PHASES          = 8;
    localparam int            ITEMS_PER_PHASE = 60;
    localparam int            POOL_SIZE       = 24;
    localparam int            HOLD_CYCLES     = 64;
    localparam int            HOLD_PHASE      = 2;
    localparam int            PAUSE_PHASE     = 4;
    localparam int            CALM_PHASE      = 6;
    localparam int            SETTLE_CYCLES   = 4;
    localparam int            WATCHDOG_LIMIT  = 2000;
    localparam lfu_pkg::key_t KEY_MAX         = lfu_pkg::key_t'(32'h7FFF_FFFF);
    localparam lfu_pkg::key_t KEY_MIN         = lfu_pkg::key_t'(32'h8000_0000);
    localparam lfu_pkg::key_t COLD_KEY        = lfu_pkg::key_t'(113);

    logic                      clk             = 1'b0;
    logic                      rst_n           = 1'b0;
    logic                      in_valid        = 1'b0;
    logic                      operation       = lfu_pkg::OP_GET;
    lfu_pkg::key_t             lookup_key      = '0;
    lfu_pkg::val_t             write_value     = '0;
    logic                      out_stall       = 1'b0;
    logic                      cfg_valid       = 1'b0;
    logic [lfu_pkg::CAP_W-1:0] capacity_in_use = lfu_pkg::CAP_RESET;
    logic                      in_stall;
    logic                      out_valid;
    logic                      found;
    lfu_pkg::val_t             read_value;
    logic                      evicted;
    lfu_pkg::key_t             evicted_key;
    logic                      cfg_ready;
    int                        mismatches;
    int                        lookups_in_flight;

    bit                        calm          = 1'b0;
    bit                        hold_off_req  = 1'b0;
    lfu_pkg::key_t             key_pool [POOL_SIZE];
    logic [lfu_pkg::CAP_W-1:0] cap_plan [PHASES] = '{5'd16, 5'd0, 5'd1, 5'd31,
                                                     5'd17, 5'd3, 5'd8, 5'd16};
    logic                      activity;

    assign activity = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                      (cfg_valid && cfg_ready);

    lfu_cache_table_unit dut (.*);

    lfu_result_checker u_result_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_item(input logic op, input lfu_pkg::key_t k,
                             input lfu_pkg::val_t v);
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        lookup_key  <= k;
        write_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lookups_in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
        cfg_valid       <= 1'b1;
        capacity_in_use <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic lfu_pkg::key_t pick_key();
        if ($urandom_range(99) < 75)
            return key_pool[$urandom_range(POOL_SIZE-1)];
        return lfu_pkg::key_t'($urandom);
    endfunction

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 18);
        end
    end

    initial
    begin
        int stale;
        stale = 0;
        while (stale < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || activity)
                stale = 0;
            else
                stale++;
        end
        $display("lfu_cache_table_unit regression: fail");
        $finish;
    end

    initial
    begin
        int p;
        int n;
        foreach (key_pool[i])
            key_pool[i] = lfu_pkg::key_t'($urandom);
        key_pool[0] = KEY_MAX;
        key_pool[1] = KEY_MIN;
        key_pool[2] = '0;
        key_pool[3] = lfu_pkg::key_t'(-1);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(lfu_pkg::OP_GET, '0, '0);
        send_item(lfu_pkg::OP_PUT, KEY_MAX, lfu_pkg::val_t'(32'h8000_0000));
        send_item(lfu_pkg::OP_PUT, KEY_MIN, lfu_pkg::val_t'(32'h7FFF_FFFF));
        send_item(lfu_pkg::OP_GET, KEY_MAX, '0);
        send_item(lfu_pkg::OP_PUT, '0, '0);
        send_item(lfu_pkg::OP_PUT, lfu_pkg::key_t'(-1), lfu_pkg::val_t'(-1));
        send_item(lfu_pkg::OP_GET, lfu_pkg::key_t'(-1), '0);
        send_item(lfu_pkg::OP_PUT, '0, lfu_pkg::val_t'(123));
        send_item(lfu_pkg::OP_GET, lfu_pkg::key_t'(5), '0);
        for (int k = 100; k < 114; k++)
            send_item(lfu_pkg::OP_PUT, lfu_pkg::key_t'(k), lfu_pkg::val_t'($urandom));
        send_item(lfu_pkg::OP_GET, KEY_MIN, '0);

        // warm most keys back to back, then force evictions
        calm = 1'b1;
        repeat (10)
        begin
            for (int k = 101; k < 113; k++)
                send_item(lfu_pkg::OP_GET, lfu_pkg::key_t'(k), '0);
            send_item(lfu_pkg::OP_GET, KEY_MAX, '0);
            send_item(lfu_pkg::OP_GET, '0, '0);
            send_item(lfu_pkg::OP_GET, lfu_pkg::key_t'(-1), '0);
        end
        for (int k = 200; k < 204; k++)
            send_item(lfu_pkg::OP_PUT, lfu_pkg::key_t'(k), lfu_pkg::val_t'($urandom));
        send_item(lfu_pkg::OP_GET, COLD_KEY, '0);
        calm = 1'b0;

        for (p = 0; p < PHASES; p++)
        begin
            wait_for_results();
            set_capacity(cap_plan[p]);
            calm = (p == CALM_PHASE);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == HOLD_PHASE && n == 10)
                    hold_off_req = 1'b1;
                if (p == PAUSE_PHASE && n == 40)
                    wait_for_results();
                send_item(logic'($urandom_range(1)), pick_key(),
                          lfu_pkg::val_t'($urandom));
            end
        end
        calm = 1'b0;
        wait_for_results();
        repeat (10) @(posedge clk);

        if (mismatches == 0 && lookups_in_flight == 0)
            $display("lfu_cache_table_unit regression: pass");
        else
            $display("lfu_cache_table_unit regression: fail");
        $finish;
    end

endmodule

/* lfu_cache_table_unit.f */
src/lfu_pkg.sv
src/lfu_victim_sel.sv
src/lfu_cache_table_unit.sv
src/lfu_checker.sv
test/lfu_result_checker.sv
test/tb.sv
